@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rational arithmetic unit modules
// every module that uses them has ports named clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle
`define RAU_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// condition in the next cycle
`define RAU_ASSERT_NXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/core/rau_pkg.sv @@
// rational arithmetic unit package: field widths, command and status codes,
// transaction structs and the unit status struct; no dependencies
`timescale 1ns / 1ps

package rau_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int CMD_BITS          = 3;
   localparam int FIELD_BITS        = 32;
   localparam int DEN_BITS          = 31;
   localparam int STATUS_BITS       = 2;

   // operation codes
   localparam logic [CMD_BITS-1:0] CMD_ADD = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_SUB = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_MUL = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_DIV = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_CMP = 3'd4;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [CMD_BITS-1:0]          cmd;
      logic signed [FIELD_BITS-1:0] a_num;
      logic signed [FIELD_BITS-1:0] a_den;
      logic signed [FIELD_BITS-1:0] b_num;
      logic signed [FIELD_BITS-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] res_num;
      logic [DEN_BITS-1:0]          res_den;
      logic                         less;
      logic                         equal;
      logic [STATUS_BITS-1:0]       status;
   } rsp_type;

   // status of an iterative unit toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

@@ rtl/core/rau_mul.sv @@
// shared multiplier of the rational arithmetic unit: one product per cycle,
// registered output; depends on rau_pkg
`timescale 1ns / 1ps

module rau_mul #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic [WORD_BITS-1:0]     op_a,
   input  logic [WORD_BITS-1:0]     op_b,
   output logic [2*WORD_BITS-1:0]   product
);

   localparam int DW = 2 * WORD_BITS;

   logic [DW-1:0] product_ff;
   logic [DW-1:0] product_in;

   // unsigned magnitude product
   assign product_in = DW'(op_a) * DW'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ rtl/core/rau_gcd.sv @@
// binary gcd unit of the rational arithmetic unit: one shift or subtract
// step per cycle, then restores the common power of two; depends on rau_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rau_gcd #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2*WORD_BITS-1:0]   x,
   input  logic [2*WORD_BITS-1:0]   y,
   output logic [2*WORD_BITS-1:0]   gcd_value,
   output rau_pkg::unit_status_type status
);

   localparam int DW = 2 * WORD_BITS;
   localparam int KW = $clog2(DW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_RESTORE
   } state_type;

   state_type     state_ff, state_in;
   logic [DW-1:0] u_ff, u_in;
   logic [DW-1:0] v_ff, v_in;
   logic [KW-1:0] k_ff, k_in;

   // step logic
   always_comb begin
      state_in = state_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               u_in     = x;
               v_in     = y;
               k_in     = '0;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (u_ff == '0 || v_ff == '0) begin
               u_in     = u_ff | v_ff;
               v_in     = '0;
               state_in = ST_RESTORE;
            end else if (!u_ff[0] && !v_ff[0]) begin
               // common factor of two
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         ST_RESTORE: begin
            // shift the common twos back in, one per cycle
            if (k_ff != '0) begin
               u_in = u_ff << 1;
               k_in = k_ff - 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
   end

   assign gcd_value   = u_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_RESTORE) && (k_ff == '0);

   // a finished gcd of operands that are not both zero is never zero
   `RAU_ASSERT_IMP(gcd_done_nonzero, status.done, u_ff != '0, "gcd finished with zero")

endmodule

@@ rtl/core/rau_div.sv @@
// restoring divider of the rational arithmetic unit: one quotient bit per
// cycle over the double-width word; depends on rau_pkg
`timescale 1ns / 1ps

module rau_div #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2*WORD_BITS-1:0]   dividend,
   input  logic [2*WORD_BITS-1:0]   divisor,
   output logic [2*WORD_BITS-1:0]   quotient,
   output rau_pkg::unit_status_type status
);

   localparam int DW = 2 * WORD_BITS;
   localparam int CW = $clog2(DW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsor_ff, dsor_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DW:0]   trial;

   // trial subtract of the shifted remainder
   assign trial = {rem_ff, quo_ff[DW-1]} - {1'b0, dsor_ff};

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsor_in  = dsor_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               quo_in   = dividend;
               rem_in   = '0;
               dsor_in  = divisor;
               count_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            quo_in   = {quo_ff[DW-2:0], !trial[DW]};
            rem_in   = trial[DW] ? {rem_ff[DW-2:0], quo_ff[DW-1]} : trial[DW-1:0];
            count_in = count_ff + 1'b1;
            if (count_ff == CW'(DW - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsor_ff  <= dsor_in;
      count_ff <= count_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_FINISH);

endmodule

@@ rtl/core/rational_arithmetic_unit.sv @@
// sequence: operand checks (an input error ends there), three products on the shared
// multiplier, combine (compare ends there), the binary gcd loop with its restore shifts,
// two divides by the gcd and a range check
// throughput: one transaction at a time, set by the gcd loop and two serial divides
// on one divider; a new transaction is taken while a finished result waits to go out
// reset: synchronous, clears the sequencer and the result valid; no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rational_arithmetic_unit #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rau_pkg::rsp_type rsp_data
);

   localparam int DW = 2 * WORD_BITS;
   localparam logic [DW-1:0] SIGN_MAG = DW'(1) << (WORD_BITS - 1);
   localparam logic [DW-1:0] POS_MAX  = SIGN_MAG - 1'b1;
   localparam logic [1:0]    MUL_LAST = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_COMBINE,
      ST_GCD_GO,
      ST_GCD_WAIT,
      ST_DIVN_GO,
      ST_DIVN_WAIT,
      ST_DIVD_GO,
      ST_DIVD_WAIT,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // split a raw field into magnitude and sign
   function automatic logic [WORD_BITS:0] take(input logic [rau_pkg::FIELD_BITS-1:0] raw);
      logic [WORD_BITS-1:0] v;
      v = raw[WORD_BITS-1:0];
      return {v[WORD_BITS-1], (v[WORD_BITS-1] ? (-v) : v)};
   endfunction

   // result for an error or overflow transaction, and the base of the ok results
   function automatic rau_pkg::rsp_type fail_rsp(input logic [rau_pkg::STATUS_BITS-1:0] st);
      rau_pkg::rsp_type r;
      r.res_num = '0;
      r.res_den = (rau_pkg::DEN_BITS)'(1);
      r.less    = 1'b0;
      r.equal   = 1'b0;
      r.status  = st;
      return r;
   endfunction

   state_type                     state_ff, state_in;
   logic [rau_pkg::CMD_BITS-1:0]  cmd_ff, cmd_in;
   logic [WORD_BITS-1:0]          ma_ff, ma_in, mda_ff, mda_in;
   logic [WORD_BITS-1:0]          mb_ff, mb_in, mdb_ff, mdb_in;
   logic                          sa_ff, sa_in, sb_ff, sb_in;
   logic [1:0]                    mstep_ff, mstep_in;
   logic [DW-1:0]                 p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [DW-1:0]                 mag_ff, mag_in, den_ff, den_in;
   logic                          neg_ff, neg_in;
   rau_pkg::rsp_type              res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rau_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic [WORD_BITS:0]            ta, tda, tb, tdb;
   logic [WORD_BITS-1:0]          mul_a, mul_b;
   logic [DW-1:0]                 product;
   logic                          gcd_start, div_start;
   logic [DW-1:0]                 gcd_value, div_dividend, quotient;
   rau_pkg::unit_status_type      gcd_status, div_status;
   logic                          input_err, rsp_push;
   logic                          yn;
   logic [DW-1:0]                 sm_mag, comb_mag, comb_den;
   logic                          sm_neg, comb_neg;
   rau_pkg::rsp_type              cmp_rsp, chk_rsp;
   logic [DW-1:0]                 chk_den;
   logic                          chk_ovf;
   logic signed [WORD_BITS-1:0]   chk_num;

   // operand magnitudes and signs
   assign ta  = take(req_data.a_num);
   assign tda = take(req_data.a_den);
   assign tb  = take(req_data.b_num);
   assign tdb = take(req_data.b_den);

   // zero denominators, unused codes, divide by zero
   assign input_err = (mda_ff == '0) || (mdb_ff == '0) || (cmd_ff > rau_pkg::CMD_CMP) ||
                      ((cmd_ff == rau_pkg::CMD_DIV) && (mb_ff == '0));

   // multiplier operand select per step
   always_comb begin
      mul_a = mda_ff;
      mul_b = mdb_ff;
      case (mstep_ff)
         2'd0: begin
            mul_a = ma_ff;
            mul_b = (cmd_ff == rau_pkg::CMD_MUL) ? mb_ff : mdb_ff;
         end
         2'd1: begin
            if (cmd_ff == rau_pkg::CMD_MUL) begin
               mul_a = mda_ff;
               mul_b = mdb_ff;
            end else if (cmd_ff == rau_pkg::CMD_DIV) begin
               mul_a = mda_ff;
               mul_b = mb_ff;
            end else begin
               mul_a = mb_ff;
               mul_b = mda_ff;
            end
         end
         default: begin
            mul_a = mda_ff;
            mul_b = mdb_ff;
         end
      endcase
   end

   // signed sum of the cross products, sign-magnitude
   assign yn = ((cmd_ff == rau_pkg::CMD_SUB) || (cmd_ff == rau_pkg::CMD_CMP)) ?
               (!sb_ff && (mb_ff != '0)) : sb_ff;

   always_comb begin
      if (sa_ff == yn) begin
         sm_mag = p0_ff + p1_ff;
         sm_neg = sa_ff;
      end else if (p0_ff >= p1_ff) begin
         sm_mag = p0_ff - p1_ff;
         sm_neg = sa_ff;
      end else begin
         sm_mag = p1_ff - p0_ff;
         sm_neg = yn;
      end
      if (sm_mag == '0) begin
         sm_neg = 1'b0;
      end
   end

   // unreduced numerator and denominator
   always_comb begin
      if ((cmd_ff == rau_pkg::CMD_MUL) || (cmd_ff == rau_pkg::CMD_DIV)) begin
         comb_mag = p0_ff;
         comb_neg = (sa_ff != sb_ff) && (p0_ff != '0);
         comb_den = p1_ff;
      end else begin
         comb_mag = sm_mag;
         comb_neg = sm_neg;
         comb_den = p2_ff;
      end
   end

   // compare result
   always_comb begin
      cmp_rsp         = fail_rsp(rau_pkg::STATUS_OK);
      cmp_rsp.less    = (sm_mag != '0) && sm_neg;
      cmp_rsp.equal   = (sm_mag == '0);
   end

   // range check and packing of the reduced fraction
   always_comb begin
      chk_den = (mag_ff == '0) ? DW'(1) : den_ff;
      chk_ovf = (neg_ff ? (mag_ff > SIGN_MAG) : (mag_ff > POS_MAX)) || (chk_den > POS_MAX);
      chk_num = neg_ff ? (-mag_ff[WORD_BITS-1:0]) : mag_ff[WORD_BITS-1:0];
      if (chk_ovf) begin
         chk_rsp = fail_rsp(rau_pkg::STATUS_OVERFLOW);
      end else begin
         chk_rsp         = fail_rsp(rau_pkg::STATUS_OK);
         chk_rsp.res_num = (rau_pkg::FIELD_BITS)'(chk_num);
         chk_rsp.res_den = (rau_pkg::DEN_BITS)'(chk_den);
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_push     = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign div_dividend = (state_ff == ST_DIVD_GO) ? den_ff : mag_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      ma_in     = ma_ff;
      mda_in    = mda_ff;
      mb_in     = mb_ff;
      mdb_in    = mdb_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      mstep_in  = mstep_ff;
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      mag_in    = mag_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      res_in    = res_ff;
      gcd_start = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               ma_in    = ta[WORD_BITS-1:0];
               mda_in   = tda[WORD_BITS-1:0];
               mb_in    = tb[WORD_BITS-1:0];
               mdb_in   = tdb[WORD_BITS-1:0];
               sa_in    = (ta[WORD_BITS] != tda[WORD_BITS]) && (ta[WORD_BITS-1:0] != '0);
               sb_in    = (tb[WORD_BITS] != tdb[WORD_BITS]) && (tb[WORD_BITS-1:0] != '0);
               mstep_in = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (input_err) begin
               res_in   = fail_rsp(rau_pkg::STATUS_ZERO_DEN);
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // product of the previous step arrives now
            if (mstep_ff == 2'd1) begin
               p0_in = product;
            end
            if (mstep_ff == 2'd2) begin
               p1_in = product;
            end
            if (mstep_ff == MUL_LAST) begin
               p2_in    = product;
               state_in = ST_COMBINE;
            end
            mstep_in = mstep_ff + 1'b1;
         end
         ST_COMBINE: begin
            mag_in = comb_mag;
            neg_in = comb_neg;
            den_in = comb_den;
            if (cmd_ff == rau_pkg::CMD_CMP) begin
               res_in   = cmp_rsp;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_GCD_GO;
            end
         end
         ST_GCD_GO: begin
            gcd_start = 1'b1;
            state_in  = ST_GCD_WAIT;
         end
         ST_GCD_WAIT: begin
            if (gcd_status.done) begin
               state_in = ST_DIVN_GO;
            end
         end
         ST_DIVN_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVN_WAIT;
         end
         ST_DIVN_WAIT: begin
            if (div_status.done) begin
               mag_in   = quotient;
               state_in = ST_DIVD_GO;
            end
         end
         ST_DIVD_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVD_WAIT;
         end
         ST_DIVD_WAIT: begin
            if (div_status.done) begin
               den_in   = quotient;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_in   = chk_rsp;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_push) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   assign rsp_valid_in = rsp_push || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = rsp_push ? res_ff : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      ma_ff       <= ma_in;
      mda_ff      <= mda_in;
      mb_ff       <= mb_in;
      mdb_ff      <= mdb_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      mstep_ff    <= mstep_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      mag_ff      <= mag_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rau_mul #(
      .WORD_BITS (WORD_BITS)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   rau_gcd #(
      .WORD_BITS (WORD_BITS)
   ) u_gcd (
      .clock     (clock),
      .reset     (reset),
      .start     (gcd_start),
      .x         (mag_ff),
      .y         (den_ff),
      .gcd_value (gcd_value),
      .status    (gcd_status)
   );

   rau_div #(
      .WORD_BITS (WORD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd_value),
      .quotient (quotient),
      .status   (div_status)
   );

   // an accepted transaction always goes through the operand checks first
   `RAU_ASSERT_NXT(accept_to_prep, req_valid && !req_stall, state_ff == ST_PREP, "accept did not start prep")
   // iterative units are quiet whenever the sequencer is idle
   `RAU_ASSERT_IMP(idle_units_quiet, state_ff == ST_IDLE, !gcd_status.busy && !div_status.busy, "unit busy while idle")
   // failed transactions report zero over one with no flags
   `RAU_ASSERT_IMP(fail_shape, rsp_valid_ff && rsp_data_ff.status != rau_pkg::STATUS_OK, rsp_data_ff.res_num == '0 && rsp_data_ff.res_den == 1 && !rsp_data_ff.less && !rsp_data_ff.equal, "bad error result")
   // good results carry a positive denominator and exclusive flags
   `RAU_ASSERT_IMP(ok_shape, rsp_valid_ff && rsp_data_ff.status == rau_pkg::STATUS_OK, rsp_data_ff.res_den != '0 && !(rsp_data_ff.less && rsp_data_ff.equal), "bad ok result")

endmodule
